@@ hdl/hfbk_pkg.sv @@
package hfbk_pkg;

	localparam int KEY_SLOTS_DEF = 6;
	localparam int OUT_SLOTS     = 6;
	localparam int OUT_W         = 8 * (OUT_SLOTS + 1);
	localparam int IN_W          = 64;

	localparam logic [15:0] PAGE_KEYBOARD = 16'h0007;
	localparam logic [15:0] KEY_LOW       = 16'h0004;
	localparam logic [15:0] KEY_HIGH      = 16'h0065;
	localparam logic [15:0] MOD_LOW       = 16'h00E0;
	localparam logic [15:0] MOD_HIGH      = 16'h00E7;

endpackage

@@ hdl/hid_fields_to_boot_keyboard_report.sv @@
// Boot-keyboard report builder, one HID field per transaction.
// The last field goes to the input stage register, its snapshot to the output register.
// Throughput: one field per cycle; the output register lets the next field in while a
// snapshot waits, and only a second snapshot blocked behind a stalled one holds the input.
// Reset: arst_n clears the key slots, modifiers and all valid flags at once.
module hid_fields_to_boot_keyboard_report #(
	parameter int KEY_SLOTS = hfbk_pkg::KEY_SLOTS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	// hid_page [15:0], usage_code [31:16], field_value [63:32]
	input  logic [hfbk_pkg::IN_W-1:0]  s_axis_tdata,
	input  logic                       s_axis_tlast,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// modifier_bits [7:0], key_slot_0 [15:8] .. key_slot_5 [55:48]
	output logic [hfbk_pkg::OUT_W-1:0] m_axis_tdata
);

	localparam int FILL_W = $clog2(KEY_SLOTS + 1);

	logic                      valid_s1;
	logic [hfbk_pkg::IN_W-1:0] data_s1;
	logic                      last_s1;

	logic [7:0]        mod_q;
	logic [7:0]        store_q [KEY_SLOTS];
	logic [FILL_W-1:0] fill_q;
	logic              seen_q;

	logic [7:0]        mod_nx;
	logic [7:0]        store_nx [KEY_SLOTS];
	logic [FILL_W-1:0] fill_nx;
	logic              seen_nx;

	logic [15:0] page;
	logic [15:0] code;
	logic        nonzero;
	logic        is_kbd;
	logic        is_mod;
	logic        is_key;
	logic        hit;
	logic        emit;
	logic        advance;

	logic                       out_valid_q;
	logic [hfbk_pkg::OUT_W-1:0] out_data_q;
	logic [hfbk_pkg::OUT_W-1:0] snap;

	assign page    = data_s1[15:0];
	assign code    = data_s1[31:16];
	assign nonzero = |data_s1[63:32];
	assign is_kbd  = page == hfbk_pkg::PAGE_KEYBOARD;
	assign is_mod  = is_kbd && code >= hfbk_pkg::MOD_LOW && code <= hfbk_pkg::MOD_HIGH;
	assign is_key  = is_kbd && !is_mod && nonzero
		&& code >= hfbk_pkg::KEY_LOW && code <= hfbk_pkg::KEY_HIGH;

	always_comb begin
		hit     = 1'b0;
		mod_nx  = mod_q;
		fill_nx = fill_q;
		seen_nx = seen_q || is_kbd;
		for (int i = 0; i < KEY_SLOTS; i++) begin
			store_nx[i] = store_q[i];
			if (FILL_W'(i) < fill_q && store_q[i] == code[7:0]) begin
				hit = 1'b1;
			end
		end
		if (is_mod && nonzero) begin
			mod_nx = mod_q | (8'b1 << code[2:0]);
		end
		if (is_key && !hit && fill_q < FILL_W'(KEY_SLOTS)) begin
			for (int i = 0; i < KEY_SLOTS; i++) begin
				if (FILL_W'(i) == fill_q) begin
					store_nx[i] = code[7:0];
				end
			end
			fill_nx = fill_q + FILL_W'(1);
		end
	end

	assign snap[7:0] = mod_nx;
	for (genvar j = 0; j < hfbk_pkg::OUT_SLOTS; j++) begin : g_slot
		if (j < KEY_SLOTS) begin : g_used
			assign snap[8*(j+1) +: 8] = store_nx[j];
		end else begin : g_zero
			assign snap[8*(j+1) +: 8] = 8'h00;
		end
	end

	// hold a snapshot-producing field while the output register is still full
	assign emit          = valid_s1 && last_s1 && seen_nx;
	assign advance       = valid_s1 && (!emit || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			data_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q  <= '0;
			fill_q <= '0;
			seen_q <= 1'b0;
			for (int i = 0; i < KEY_SLOTS; i++) begin
				store_q[i] <= '0;
			end
		end else if (advance) begin
			if (last_s1) begin
				mod_q  <= '0;
				fill_q <= '0;
				seen_q <= 1'b0;
				for (int i = 0; i < KEY_SLOTS; i++) begin
					store_q[i] <= '0;
				end
			end else begin
				mod_q  <= mod_nx;
				fill_q <= fill_nx;
				seen_q <= seen_nx;
				for (int i = 0; i < KEY_SLOTS; i++) begin
					store_q[i] <= store_nx[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_data_q <= snap;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

@@ hdl/hfbk_checker.sv @@
module hfbk_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_axis_tvalid,
	input logic                       s_axis_tready,
	input logic [hfbk_pkg::IN_W-1:0]  s_axis_tdata,
	input logic                       s_axis_tlast,
	input logic                       m_axis_tvalid,
	input logic                       m_axis_tready,
	input logic [hfbk_pkg::OUT_W-1:0] m_axis_tdata
);

	// a waiting input transaction holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata)
			&& $stable(s_axis_tlast))
		else $error("input transaction changed while waiting");

	// a stalled snapshot holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("snapshot changed while stalled");

	// the first and last key slots only ever carry key usages or zero
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[15:8] == 8'h00
			|| (m_axis_tdata[15:8] >= 8'h04 && m_axis_tdata[15:8] <= 8'h65))
			&& (m_axis_tdata[55:48] == 8'h00
			|| (m_axis_tdata[55:48] >= 8'h04 && m_axis_tdata[55:48] <= 8'h65)))
		else $error("key slot outside key usage range");

	// slots fill from the lowest, so an empty first slot is followed by empty ones
	a_slot_packed: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[15:8] == 8'h00 |-> m_axis_tdata[55:16] == '0)
		else $error("key slots not packed");

	// the second slot never repeats the key in the first
	a_no_dup: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[23:16] != 8'h00
			|-> m_axis_tdata[23:16] != m_axis_tdata[15:8])
		else $error("duplicate key in slots");

endmodule

bind hid_fields_to_boot_keyboard_report hfbk_checker u_hfbk_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

@@ bench/tb_hid_fields_to_boot_keyboard_report.sv @@
module tb_hid_fields_to_boot_keyboard_report;

	localparam int SLOT_COUNT = hfbk_pkg::KEY_SLOTS_DEF;
	localparam int RANDOM_FIELDS = 1450;

	typedef struct {
		logic [15:0]        hid_page;
		logic [15:0]        usage_code;
		logic signed [31:0] field_value;
		logic               last_field;
	} hid_field_t;

	// modifier_bits in the low byte, key_slot[0] next, up to key_slot[OUT_SLOTS-1]
	typedef struct packed {
		logic [hfbk_pkg::OUT_SLOTS-1:0][7:0] key_slot;
		logic [7:0]                          modifier_bits;
	} boot_report_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       s_axis_tvalid = 1'b0;
	logic                       s_axis_tready;
	logic [hfbk_pkg::IN_W-1:0]  s_axis_tdata = '0;
	logic                       s_axis_tlast = 1'b0;
	logic                       m_axis_tvalid;
	logic                       m_axis_tready = 1'b0;
	logic [hfbk_pkg::OUT_W-1:0] m_axis_tdata;

	hid_field_t   field_queue[$];
	boot_report_t report_queue[$];

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int          fail_count = 0;

	// predictor state
	logic [7:0] mod_accum = '0;
	logic [7:0] held_keys [SLOT_COUNT];
	int         held_count = 0;
	bit         kbd_seen = 1'b0;

	hid_fields_to_boot_keyboard_report u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Fold one accepted field into the running report; on the last field, queue a snapshot if a keyboard field was seen.
	function automatic void track_field(hid_field_t f);
		boot_report_t snap;
		bit           dup;
		bit           nonzero;
		nonzero = (f.field_value != 0);
		if (f.hid_page == hfbk_pkg::PAGE_KEYBOARD) begin
			kbd_seen = 1'b1;
			if (f.usage_code >= hfbk_pkg::MOD_LOW && f.usage_code <= hfbk_pkg::MOD_HIGH) begin
				if (nonzero)
					mod_accum[f.usage_code[2:0]] = 1'b1;
			end else if (nonzero && f.usage_code >= hfbk_pkg::KEY_LOW
				&& f.usage_code <= hfbk_pkg::KEY_HIGH) begin
				dup = 1'b0;
				for (int i = 0; i < held_count; i++)
					if (held_keys[i] == f.usage_code[7:0])
						dup = 1'b1;
				// drop repeats and any key past the last slot
				if (!dup && held_count < SLOT_COUNT) begin
					held_keys[held_count] = f.usage_code[7:0];
					held_count++;
				end
			end
		end
		if (f.last_field) begin
			if (kbd_seen) begin
				snap.modifier_bits = mod_accum;
				for (int j = 0; j < hfbk_pkg::OUT_SLOTS; j++)
					snap.key_slot[j] = (j < held_count) ? held_keys[j] : 8'h00;
				report_queue.push_back(snap);
			end
			mod_accum = '0;
			for (int i = 0; i < SLOT_COUNT; i++)
				held_keys[i] = 8'h00;
			held_count = 0;
			kbd_seen = 1'b0;
		end
	endfunction

	function automatic void check_boot_report(boot_report_t got);
		boot_report_t want;
		if (report_queue.size() == 0) begin
			$error("report with no expectation: %h", got);
			fail_count++;
		end else begin
			want = report_queue.pop_front();
			if (got.modifier_bits !== want.modifier_bits) begin
				$error("modifier_bits: expected %h, actual %h", want.modifier_bits,
					got.modifier_bits);
				fail_count++;
			end
			for (int j = 0; j < hfbk_pkg::OUT_SLOTS; j++)
				if (got.key_slot[j] !== want.key_slot[j]) begin
					$error("key_slot_%0d: expected %h, actual %h", j, want.key_slot[j],
						got.key_slot[j]);
					fail_count++;
				end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tlast <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				track_field(field_queue.pop_front());
			if (s_axis_tvalid && !s_axis_tready) begin
				// hold the pending transaction
			end else if (field_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {field_queue[0].field_value, field_queue[0].usage_code,
					field_queue[0].hid_page};
				s_axis_tlast <= field_queue[0].last_field;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				check_boot_report(m_axis_tdata);
			m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	task automatic push_field(input logic [15:0] page, input logic [15:0] code,
		input logic [31:0] value, input logic last);
		hid_field_t f;
		f.hid_page = page;
		f.usage_code = code;
		f.field_value = value;
		f.last_field = last;
		field_queue.push_back(f);
	endtask

	function automatic logic [15:0] pick_code();
		logic [15:0] code;
		case ($urandom_range(0, 19)) inside
			[0:6]:   code = 16'h0004 + 16'($urandom_range(0, 7));
			[7:10]:  code = 16'($urandom_range(hfbk_pkg::KEY_LOW, hfbk_pkg::KEY_HIGH));
			[11:14]: code = 16'($urandom_range(hfbk_pkg::MOD_LOW, hfbk_pkg::MOD_HIGH));
			[15:16]: begin
				case ($urandom_range(0, 7))
					0: code = 16'h0000;
					1: code = 16'h0003;
					2: code = 16'h0066;
					3: code = 16'h00DF;
					4: code = 16'h00E8;
					5: code = 16'h00FF;
					6: code = 16'hFFFF;
					default: code = 16'h0104;
				endcase
			end
			default: code = 16'($urandom_range(0, 16'hFFFF));
		endcase
		return code;
	endfunction

	function automatic logic [31:0] pick_value();
		logic [31:0] value;
		case ($urandom_range(0, 9)) inside
			[0:1]: value = 32'h0000_0000;
			2: begin
				case ($urandom_range(0, 3))
					0: value = 32'h8000_0000;
					1: value = 32'h7FFF_FFFF;
					2: value = 32'hFFFF_FFFF;
					default: value = 32'h0000_0001;
				endcase
			end
			default: value = $urandom;
		endcase
		return value;
	endfunction

	// Mostly well-formed keyboard reports; some carry only foreign-page noise.
	task automatic push_report(inout int count);
		int          len;
		bit          noise;
		logic [15:0] page;
		len = $urandom_range(1, 12);
		noise = ($urandom_range(0, 9) == 0);
		for (int i = 0; i < len; i++) begin
			case ($urandom_range(0, 19)) inside
				[0:1]:   page = 16'($urandom_range(0, 16'hFFFF));
				2:       page = 16'h0007 | (16'($urandom_range(1, 16'h1FFF)) << 3);
				default: page = hfbk_pkg::PAGE_KEYBOARD;
			endcase
			if (noise && page == hfbk_pkg::PAGE_KEYBOARD)
				page = 16'h000C;
			push_field(page, pick_code(), pick_value(), i == len - 1);
			count++;
		end
	endtask

	initial begin
		int pushed;
		int target;
		for (int i = 0; i < SLOT_COUNT; i++)
			held_keys[i] = 8'h00;
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// modifiers at both ends, zero modifier, range edges, repeat, extreme values
		push_field(hfbk_pkg::PAGE_KEYBOARD, 16'h00E0, 32'h0000_0001, 1'b0);
		push_field(hfbk_pkg::PAGE_KEYBOARD, 16'h00E7, 32'hFFFF_FFFF, 1'b0);
		push_field(hfbk_pkg::PAGE_KEYBOARD, 16'h00E3, 32'h0000_0000, 1'b0);
		push_field(hfbk_pkg::PAGE_KEYBOARD, 16'h0004, 32'h8000_0000, 1'b0);
		push_field(hfbk_pkg::PAGE_KEYBOARD, 16'h0065, 32'h7FFF_FFFF, 1'b0);
		push_field(hfbk_pkg::PAGE_KEYBOARD, 16'h0004, 32'h0000_0001, 1'b0);
		push_field(hfbk_pkg::PAGE_KEYBOARD, 16'h0003, 32'h0000_0001, 1'b0);
		push_field(hfbk_pkg::PAGE_KEYBOARD, 16'h0066, 32'h0000_0001, 1'b1);
		// seven distinct keys: the last one is dropped
		for (int i = 0; i < 7; i++)
			push_field(hfbk_pkg::PAGE_KEYBOARD, 16'h0010 + 16'(i), 32'h0000_0002, i == 6);
		// foreign pages only: no report
		push_field(16'hFFFF, 16'h00E0, 32'h0000_0001, 1'b0);
		push_field(16'h0000, 16'h0004, 32'h0000_0001, 1'b1);
		// single keyboard field outside both ranges
		push_field(hfbk_pkg::PAGE_KEYBOARD, 16'hFFFF, 32'h0000_0000, 1'b1);
		push_field(hfbk_pkg::PAGE_KEYBOARD, 16'h00E8, 32'h0000_0001, 1'b0);
		push_field(hfbk_pkg::PAGE_KEYBOARD, 16'h00DF, 32'h0000_0001, 1'b0);
		push_field(16'h0107, 16'h0005, 32'h0000_0001, 1'b0);
		push_field(hfbk_pkg::PAGE_KEYBOARD, 16'h0104, 32'h0000_0001, 1'b1);
		while (field_queue.size() != 0)
			@(posedge clk);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
				default: begin send_idle_pct = 29; recv_stall_pct = 29; end
			endcase
			pushed = 0;
			target = RANDOM_FIELDS / 4;
			while (pushed < target)
				push_report(pushed);
			while (field_queue.size() != 0)
				@(posedge clk);
		end

		while (report_queue.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

@@ hid_fields_to_boot_keyboard_report.f @@
hdl/hfbk_pkg.sv
hdl/hid_fields_to_boot_keyboard_report.sv
hdl/hfbk_checker.sv
bench/tb_hid_fields_to_boot_keyboard_report.sv
